@@ rtl/dwpid_pkg.sv @@
// Shared types and constants for the two-wheel encoder PID speed controller.
`timescale 1ns / 1ps
`default_nettype none

package dwpid_pkg;

	// Event codes carried by an input transaction.
	typedef enum logic [1:0] {
		MODE_LEFT  = 2'd0,
		MODE_RIGHT = 2'd1,
		MODE_TICK  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEFT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 3'd7;
	localparam int unsigned CFG_DATA_W = 16;

	// Reset values of the configuration registers.
	localparam logic [15:0] GAIN_PROP_RST   = 16'd6400;
	localparam logic [15:0] GAIN_INTEG_RST  = 16'd184;
	localparam logic [15:0] GAIN_DERIV_RST  = 16'd550;
	localparam logic [9:0]  INTEG_LIMIT_RST = 10'd255;
	localparam logic [7:0]  DRIVE_LIMIT_RST = 8'd255;

	// Configuration register file contents.
	typedef struct packed {
		logic signed [10:0] target_left;
		logic signed [10:0] target_right;
		logic [15:0]        gain_prop;
		logic [15:0]        gain_integ;
		logic [15:0]        gain_deriv;
		logic [9:0]         integral_limit;
		logic [7:0]         drive_limit;
		logic               loop_enable;
	} cfg_t;

	// Per-wheel terms that feed the PID multipliers.
	typedef struct packed {
		logic signed [15:0] err;
		logic signed [10:0] integ;
		logic signed [16:0] diff;
	} pid_term_t;

endpackage

`default_nettype wire

@@ rtl/dwpid_cfg.sv @@
// Configuration register file for the two-wheel encoder PID speed controller.
`timescale 1ns / 1ps
`default_nettype none

module dwpid_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [dwpid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dwpid_pkg::CFG_DATA_W-1:0] cfg_data,
	output dwpid_pkg::cfg_t                       cfg
);
	import dwpid_pkg::*;

	cfg_t cfg_q;

	// Writes are always accepted.
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// Register write decode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_left    <= '0;
			cfg_q.target_right   <= '0;
			cfg_q.gain_prop      <= GAIN_PROP_RST;
			cfg_q.gain_integ     <= GAIN_INTEG_RST;
			cfg_q.gain_deriv     <= GAIN_DERIV_RST;
			cfg_q.integral_limit <= INTEG_LIMIT_RST;
			cfg_q.drive_limit    <= DRIVE_LIMIT_RST;
			cfg_q.loop_enable    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TARGET_LEFT:  cfg_q.target_left    <= cfg_data[10:0];
				CFG_TARGET_RIGHT: cfg_q.target_right   <= cfg_data[10:0];
				CFG_GAIN_PROP:    cfg_q.gain_prop      <= cfg_data[15:0];
				CFG_GAIN_INTEG:   cfg_q.gain_integ     <= cfg_data[15:0];
				CFG_GAIN_DERIV:   cfg_q.gain_deriv     <= cfg_data[15:0];
				CFG_INTEG_LIMIT:  cfg_q.integral_limit <= cfg_data[9:0];
				CFG_DRIVE_LIMIT:  cfg_q.drive_limit    <= cfg_data[7:0];
				CFG_LOOP_ENABLE:  cfg_q.loop_enable    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/dwpid_track.sv @@
// Encoder position counters and PID loop state with per-tick error terms.
`timescale 1ns / 1ps
`default_nettype none

module dwpid_track (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire dwpid_pkg::mode_t     mode_s1,
	input  wire logic                 phase_a_s1,
	input  wire logic                 phase_b_s1,
	input  wire dwpid_pkg::cfg_t      cfg,
	output dwpid_pkg::pid_term_t      term_left,
	output dwpid_pkg::pid_term_t      term_right
);
	import dwpid_pkg::*;

	logic [31:0]        left_pos_q, right_pos_q;
	logic [31:0]        left_snap_q, right_snap_q;
	logic signed [10:0] left_integ_q, right_integ_q;
	logic signed [15:0] left_last_q, right_last_q;
	logic [31:0]        left_pos_step, right_pos_step;
	logic               count_up;
	pid_term_t          calc_left, calc_right;

	// Error, clamped integral and error difference for one wheel.
	function automatic pid_term_t wheel_terms(
		input logic signed [10:0] target,
		input logic [31:0]        pos,
		input logic [31:0]        snap,
		input logic signed [10:0] integ,
		input logic signed [15:0] last,
		input logic [9:0]         ilim
	);
		logic [31:0]        delta;
		logic signed [32:0] e_wide;
		logic signed [15:0] err;
		logic signed [16:0] isum;
		logic signed [16:0] lim_p;
		logic signed [16:0] lim_n;
		pid_term_t          t;
		delta  = pos - snap;
		e_wide = 33'(target) - $signed({delta[31], delta});
		if (e_wide > 33'sd32767) begin
			err = 16'sh7fff;
		end else if (e_wide < -33'sd32768) begin
			err = 16'sh8000;
		end else begin
			err = e_wide[15:0];
		end
		isum  = 17'(integ) + 17'(err);
		lim_p = $signed({7'd0, ilim});
		lim_n = -lim_p;
		if (isum > lim_p) begin
			isum = lim_p;
		end else if (isum < lim_n) begin
			isum = lim_n;
		end
		t.err   = err;
		t.integ = isum[10:0];
		t.diff  = 17'(err) - 17'(last);
		return t;
	endfunction

	// Quadrature direction: equal phase levels count up.
	assign count_up       = (phase_a_s1 == phase_b_s1);
	assign left_pos_step  = count_up ? left_pos_q + 32'd1 : left_pos_q - 32'd1;
	assign right_pos_step = count_up ? right_pos_q + 32'd1 : right_pos_q - 32'd1;

	// Loop terms for both wheels; a disabled loop feeds zeros downstream.
	always_comb begin
		calc_left  = wheel_terms(cfg.target_left, left_pos_q, left_snap_q,
			left_integ_q, left_last_q, cfg.integral_limit);
		calc_right = wheel_terms(cfg.target_right, right_pos_q, right_snap_q,
			right_integ_q, right_last_q, cfg.integral_limit);
		term_left  = cfg.loop_enable ? calc_left : '0;
		term_right = cfg.loop_enable ? calc_right : '0;
	end

	// State update as the stage-one event retires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_pos_q    <= '0;
			right_pos_q   <= '0;
			left_snap_q   <= '0;
			right_snap_q  <= '0;
			left_integ_q  <= '0;
			right_integ_q <= '0;
			left_last_q   <= '0;
			right_last_q  <= '0;
		end else if (step) begin
			case (mode_s1)
				MODE_LEFT: begin
					left_pos_q <= left_pos_step;
				end
				MODE_RIGHT: begin
					right_pos_q <= right_pos_step;
				end
				MODE_CLEAR: begin
					left_pos_q  <= '0;
					right_pos_q <= '0;
				end
				MODE_TICK: begin
					left_snap_q   <= left_pos_q;
					right_snap_q  <= right_pos_q;
					left_integ_q  <= term_left.integ;
					right_integ_q <= term_right.integ;
					left_last_q   <= term_left.err;
					right_last_q  <= term_right.err;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/dwpid_law.sv @@
// PID products, truncating scale, drive clamp and direction split for one wheel.
`timescale 1ns / 1ps
`default_nettype none

module dwpid_law (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire dwpid_pkg::pid_term_t term,
	input  wire dwpid_pkg::cfg_t      cfg,
	output logic [7:0]                fwd,
	output logic [7:0]                rev,
	output logic signed [15:0]        err
);
	import dwpid_pkg::*;

	logic signed [32:0] p_prop_s3;
	logic signed [27:0] p_integ_s3;
	logic signed [33:0] p_deriv_s3;
	logic signed [15:0] err_s3;
	logic signed [35:0] sum;
	logic signed [35:0] sum_adj;
	logic signed [35:0] scaled;
	logic signed [35:0] lim_p;
	logic signed [35:0] lim_n;
	logic signed [35:0] drive;
	logic signed [35:0] drive_neg;

	// Gain products, registered before the sum.
	always_ff @(posedge clk) begin
		if (en) begin
			p_prop_s3  <= $signed({1'b0, cfg.gain_prop}) * term.err;
			p_integ_s3 <= $signed({1'b0, cfg.gain_integ}) * term.integ;
			p_deriv_s3 <= $signed({1'b0, cfg.gain_deriv}) * term.diff;
			err_s3     <= term.err;
		end
	end

	// Sum, divide by 256 toward zero, clamp and split by sign.
	always_comb begin
		sum       = 36'(p_prop_s3) + 36'(p_integ_s3) + 36'(p_deriv_s3);
		sum_adj   = sum + (sum[35] ? 36'sd255 : 36'sd0);
		scaled    = sum_adj >>> 8;
		lim_p     = $signed({28'd0, cfg.drive_limit});
		lim_n     = -lim_p;
		if (scaled > lim_p) begin
			drive = lim_p;
		end else if (scaled < lim_n) begin
			drive = lim_n;
		end else begin
			drive = scaled;
		end
		drive_neg = -drive;
		fwd       = drive[35] ? 8'd0 : drive[7:0];
		rev       = drive[35] ? drive_neg[7:0] : 8'd0;
		err       = err_s3;
	end

endmodule

`default_nettype wire

@@ rtl/dual_wheel_encoder_pid_speed.sv @@
// Top level of the two-wheel encoder PID speed controller.
//
//   Channel  Handshake                   Payload
//   item     item_valid / item_ready     mode, phase_a_level, phase_b_level
//   result   result_valid / result_ready duties and speed errors, per wheel
//   cfg      cfg_valid / cfg_ready       cfg_index, cfg_data
//
// One transaction is accepted per cycle while item_ready is high. A tick result passes
// through the input, term, product and result registers in turn.
// Encoder edges and count clears update state in the stage-one cycle and give no result.
// Each stage holds while the one after it is full and stalled, so a waiting result
// does not block new items until the pipeline fills. Reset clears counts, loop state
// and configuration to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module dual_wheel_encoder_pid_speed (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_ready,
	input  wire logic [1:0]                       mode,
	input  wire logic                             phase_a_level,
	input  wire logic                             phase_b_level,
	output logic                                  result_valid,
	input  wire logic                             result_ready,
	output logic [7:0]                            left_forward_duty,
	output logic [7:0]                            left_reverse_duty,
	output logic [7:0]                            right_forward_duty,
	output logic [7:0]                            right_reverse_duty,
	output logic signed [15:0]                    left_speed_error,
	output logic signed [15:0]                    right_speed_error,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [dwpid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dwpid_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dwpid_pkg::*;

	cfg_t               cfg;
	logic               v_s1, v_s2, v_s3, out_valid_q;
	mode_t              mode_s1;
	logic               phase_a_s1, phase_b_s1;
	pid_term_t          term_left, term_right;
	pid_term_t          term_left_s2, term_right_s2;
	logic               en_out, en_s3, en_s2, leave_s1;
	logic [7:0]         l_fwd, l_rev, r_fwd, r_rev;
	logic signed [15:0] l_err, r_err;
	logic [7:0]         l_fwd_q, l_rev_q, r_fwd_q, r_rev_q;
	logic signed [15:0] l_err_q, r_err_q;

	// Configuration registers.
	dwpid_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage advance: each stage loads when it is empty or its contents move on.
	assign en_out     = !out_valid_q || result_ready;
	assign en_s3      = !v_s3 || en_out;
	assign en_s2      = !v_s2 || en_s3;
	assign leave_s1   = v_s1 && ((mode_s1 != MODE_TICK) || en_s2);
	assign item_ready = !v_s1 || leave_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item_ready) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			mode_s1    <= mode_t'(mode);
			phase_a_s1 <= phase_a_level;
			phase_b_s1 <= phase_b_level;
		end
	end

	// Position counters and loop state.
	dwpid_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (leave_s1),
		.mode_s1    (mode_s1),
		.phase_a_s1 (phase_a_s1),
		.phase_b_s1 (phase_b_s1),
		.cfg        (cfg),
		.term_left  (term_left),
		.term_right (term_right)
	);

	// Term register: only control ticks travel past stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s2) begin
				v_s2 <= leave_s1 && (mode_s1 == MODE_TICK);
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			term_left_s2  <= term_left;
			term_right_s2 <= term_right;
		end
	end

	// Control law per wheel.
	dwpid_law u_law_left (
		.clk  (clk),
		.en   (en_s3),
		.term (term_left_s2),
		.cfg  (cfg),
		.fwd  (l_fwd),
		.rev  (l_rev),
		.err  (l_err)
	);

	dwpid_law u_law_right (
		.clk  (clk),
		.en   (en_s3),
		.term (term_right_s2),
		.cfg  (cfg),
		.fwd  (r_fwd),
		.rev  (r_rev),
		.err  (r_err)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			l_fwd_q <= l_fwd;
			l_rev_q <= l_rev;
			r_fwd_q <= r_fwd;
			r_rev_q <= r_rev;
			l_err_q <= l_err;
			r_err_q <= r_err;
		end
	end

	assign result_valid       = out_valid_q;
	assign left_forward_duty  = l_fwd_q;
	assign left_reverse_duty  = l_rev_q;
	assign right_forward_duty = r_fwd_q;
	assign right_reverse_duty = r_rev_q;
	assign left_speed_error   = l_err_q;
	assign right_speed_error  = r_err_q;

endmodule

`default_nettype wire
